### rtl/cke_pkg.sv
package cke_pkg;

   // Size limits and field widths
   localparam int unsigned MAX_WIDTH  = 4096;
   localparam int unsigned MAX_HEIGHT = 4096;
   localparam int unsigned SIZE_W     = 13;
   localparam int unsigned COORD_W    = 12;
   localparam int unsigned FORMAT_W   = 2;
   localparam int unsigned COLOR_W    = 24;
   localparam int unsigned PIXEL_W    = 32;
   localparam int unsigned INDEX_W    = 24;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 24;

   localparam logic [SIZE_W-1:0] MAX_WIDTH_C  = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] MAX_HEIGHT_C = SIZE_W'(MAX_HEIGHT);
   localparam logic [SIZE_W-1:0] SIZE_ONE     = SIZE_W'(1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_COLOR    = 2'd3;

   // Pixel formats; any other code acts as 32-bit
   localparam logic [FORMAT_W-1:0] FMT_RGB565 = 2'd0;
   localparam logic [FORMAT_W-1:0] FMT_RGB24  = 2'd1;
   localparam logic [FORMAT_W-1:0] FMT_RGB32  = 2'd2;

   // Zero acts as one, above the maximum saturates
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] hi);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_ONE;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Compare pixel against key 0x00BBGGRR in the pixel's own layout
   function automatic logic pixel_is_key(input logic [PIXEL_W-1:0]  pix,
                                         input logic [COLOR_W-1:0]  key,
                                         input logic [FORMAT_W-1:0] fmt);
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic [15:0] k16;
      logic [23:0] rgb;
      logic        hit;
      r   = key[7:0];
      g   = key[15:8];
      b   = key[23:16];
      k16 = {r[7:3], g[7:2], b[7:3]};
      rgb = {r, g, b};
      case (fmt)
         FMT_RGB565: hit = (pix[15:0] == k16);
         FMT_RGB24:  hit = (pix[23:0] == rgb);
         default:    hit = (pix == {8'h00, rgb});
      endcase
      return hit;
   endfunction

endpackage

### rtl/color_key_run_extractor.sv
// Color-key run extractor. Takes one raw pixel per beat in scan order (left to
// right, top to bottom) and compares it with the transparent key color set in
// csr register 3 (0x00BBGGRR, converted to RGB565 or 0x00RRGGBB per the pixel
// format). For every maximal run of non-key pixels within a scan line one
// result beat is produced: first column, line index, column just past the run
// and a running run number that restarts at each new image. A run still open
// at the end of a line closes at the line width. Throughput is one pixel per
// clock while the result side keeps up; a pixel goes to a pixel register,
// then the run logic feeds the result register. The result register decouples
// the sides: a new pixel is taken while a result waits, and ready drops only
// when both the pixel register and result register are full and rsp_ready is
// low. Configuration must be written only while idle; the block does not
// enforce it. No read-back. After reset: width 1, height 1, 24-bit, key black.
module color_key_run_extractor (
   input  logic                            clock,
   input  logic                            reset,
   // pixel input channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [cke_pkg::PIXEL_W-1:0]     req_pixel_word,
   // run result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [cke_pkg::COORD_W-1:0]     rsp_run_left,
   output logic [cke_pkg::COORD_W-1:0]     rsp_run_row,
   output logic [cke_pkg::SIZE_W-1:0]      rsp_run_right,
   output logic [cke_pkg::INDEX_W-1:0]     rsp_run_index,
   // configuration write port
   input  logic                            csr_write_enable,
   input  logic [cke_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cke_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import cke_pkg::*;

   // configuration registers
   logic [SIZE_W-1:0]   image_width_ff;
   logic [SIZE_W-1:0]   image_height_ff;
   logic [FORMAT_W-1:0] pixel_format_ff;
   logic [COLOR_W-1:0]  key_color_ff;

   // pixel register
   logic                pix_valid_ff, pix_valid_in;
   logic [PIXEL_W-1:0]  pix_word_ff;

   // scan state
   logic [COORD_W-1:0]  column_ff, column_in;
   logic [COORD_W-1:0]  row_ff, row_in;
   logic                run_open_ff, run_open_in;
   logic [COORD_W-1:0]  run_start_ff, run_start_in;
   logic [INDEX_W-1:0]  runs_emitted_ff, runs_emitted_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]  rsp_left_ff, rsp_left_in;
   logic [COORD_W-1:0]  rsp_row_ff;
   logic [SIZE_W-1:0]   rsp_right_ff, rsp_right_in;
   logic [INDEX_W-1:0]  rsp_index_ff;

   logic                advance;
   logic                process;
   logic                req_fire;
   logic                solid;
   logic                emit;
   logic                line_end;
   logic                image_end;
   logic [SIZE_W-1:0]   width_eff;
   logic [SIZE_W-1:0]   height_eff;
   logic [SIZE_W-1:0]   col_next;
   logic [SIZE_W-1:0]   row_next;

   // result slot frees up this cycle -> pixel stage may move on
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign process   = pix_valid_ff && advance;
   assign req_ready = !pix_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign width_eff  = clamp_size(image_width_ff, MAX_WIDTH_C);
   assign height_eff = clamp_size(image_height_ff, MAX_HEIGHT_C);
   assign col_next   = {1'b0, column_ff} + SIZE_ONE;
   assign row_next   = {1'b0, row_ff} + SIZE_ONE;
   assign line_end   = (col_next >= width_eff);
   assign image_end  = (row_next >= height_eff);

   assign solid = !pixel_is_key(pix_word_ff, key_color_ff, pixel_format_ff);

   // Run tracking. At most one close per pixel: a key pixel closes an open run
   // at this column; otherwise a run open after this pixel closes at line end.
   always_comb begin
      emit            = 1'b0;
      rsp_left_in     = run_start_ff;
      rsp_right_in    = {1'b0, column_ff};
      run_open_in     = run_open_ff;
      run_start_in    = run_start_ff;
      column_in       = column_ff;
      row_in          = row_ff;
      runs_emitted_in = runs_emitted_ff;

      if (run_open_ff && !solid) begin
         emit        = 1'b1;
         run_open_in = 1'b0;
      end else if (!run_open_ff && solid) begin
         run_open_in  = 1'b1;
         run_start_in = column_ff;
         rsp_left_in  = column_ff;
      end

      if (line_end) begin
         if (run_open_in) begin
            emit         = 1'b1;
            rsp_right_in = col_next;
            run_open_in  = 1'b0;
         end
         column_in = '0;
      end else begin
         column_in = col_next[COORD_W-1:0];
      end

      if (emit) begin
         runs_emitted_in = runs_emitted_ff + INDEX_W'(1);
      end

      if (line_end) begin
         if (image_end) begin
            row_in          = '0;
            runs_emitted_in = '0;
         end else begin
            row_in = row_next[COORD_W-1:0];
         end
      end
   end

   always_comb begin
      if (req_fire) begin
         pix_valid_in = 1'b1;
      end else if (advance) begin
         pix_valid_in = 1'b0;
      end else begin
         pix_valid_in = pix_valid_ff;
      end

      if (process) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= SIZE_ONE;
         image_height_ff <= SIZE_ONE;
         pixel_format_ff <= FMT_RGB24;
         key_color_ff    <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  image_width_ff  <= csr_write_data[SIZE_W-1:0];
            REG_IMAGE_HEIGHT: image_height_ff <= csr_write_data[SIZE_W-1:0];
            REG_PIXEL_FORMAT: pixel_format_ff <= csr_write_data[FORMAT_W-1:0];
            REG_KEY_COLOR:    key_color_ff    <= csr_write_data[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // control and scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         column_ff       <= '0;
         row_ff          <= '0;
         run_open_ff     <= 1'b0;
         run_start_ff    <= '0;
         runs_emitted_ff <= '0;
      end else begin
         pix_valid_ff <= pix_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (process) begin
            column_ff       <= column_in;
            row_ff          <= row_in;
            run_open_ff     <= run_open_in;
            run_start_ff    <= run_start_in;
            runs_emitted_ff <= runs_emitted_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pix_word_ff <= req_pixel_word;
      end
      if (process && emit) begin
         rsp_left_ff  <= rsp_left_in;
         rsp_row_ff   <= row_ff;
         rsp_right_ff <= rsp_right_in;
         rsp_index_ff <= runs_emitted_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_run_left  = rsp_left_ff;
   assign rsp_run_row   = rsp_row_ff;
   assign rsp_run_right = rsp_right_ff;
   assign rsp_run_index = rsp_index_ff;

endmodule

### rtl/cke_checker.sv
module cke_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [cke_pkg::COORD_W-1:0]   rsp_run_left,
   input logic [cke_pkg::COORD_W-1:0]   rsp_run_row,
   input logic [cke_pkg::SIZE_W-1:0]    rsp_run_right,
   input logic [cke_pkg::INDEX_W-1:0]   rsp_run_index
);
   import cke_pkg::*;

   // a waiting result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_run_left) &&
      $stable(rsp_run_row) && $stable(rsp_run_right) && $stable(rsp_run_index))
      else $error("result beat changed while stalled");

   // a run is never empty
   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_run_left} < rsp_run_right)
      else $error("run right edge not past left edge");

   // empty result slot never blocks the pixel side
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid following reset");

endmodule

bind color_key_run_extractor cke_checker u_cke_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_run_left  (rsp_run_left),
   .rsp_run_row   (rsp_run_row),
   .rsp_run_right (rsp_run_right),
   .rsp_run_index (rsp_run_index)
);

### dv/cke_run_checker.sv
// Watches the pixel, run and csr ports of the color-key run extractor, keeps
// its own copy of the scan state, predicts one run record per pixel beat at
// most and compares every run beat against the oldest prediction.
module cke_run_checker
   import cke_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [PIXEL_W-1:0]    req_pixel_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [COORD_W-1:0]    rsp_run_left,
   input  logic [COORD_W-1:0]    rsp_run_row,
   input  logic [SIZE_W-1:0]     rsp_run_right,
   input  logic [INDEX_W-1:0]    rsp_run_index,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output int                    fail_count,
   output int                    runs_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] row;
      logic [SIZE_W-1:0]  right;
      logic [INDEX_W-1:0] index;
   } run_rec_t;

   run_rec_t pending_runs[$];

   // shadow registers
   logic [SIZE_W-1:0]   width_reg;
   logic [SIZE_W-1:0]   height_reg;
   logic [FORMAT_W-1:0] format_reg;
   logic [COLOR_W-1:0]  key_reg;

   // scan state
   int unsigned col_pos;
   int unsigned row_pos;
   bit          in_run;
   int unsigned run_first;
   int unsigned run_number;

   initial begin
      fail_count   = 0;
      runs_pending = 0;
   end

   function automatic int unsigned usable_size(input logic [SIZE_W-1:0] v,
                                               input int unsigned top);
      int unsigned s;
      s = v;
      if (s == 0) s = 1;
      if (s > top) s = top;
      return s;
   endfunction

   function automatic bit matches_key(input logic [PIXEL_W-1:0] pix);
      logic [15:0] key16;
      logic [23:0] key24;
      bit          hit;
      key16 = {key_reg[7:3], key_reg[15:10], key_reg[23:19]};
      key24 = {key_reg[7:0], key_reg[15:8], key_reg[23:16]};
      case (format_reg)
         FMT_RGB565: hit = (pix[15:0] == key16);
         FMT_RGB24:  hit = (pix[23:0] == key24);
         default:    hit = (pix == {8'h00, key24});
      endcase
      return hit;
   endfunction

   task automatic close_run(input int unsigned left, input int unsigned right);
      run_rec_t r;
      r.left  = left[COORD_W-1:0];
      r.row   = row_pos[COORD_W-1:0];
      r.right = right[SIZE_W-1:0];
      r.index = run_number[INDEX_W-1:0];
      pending_runs.push_back(r);
      run_number = (run_number + 1) & 32'h00ff_ffff;
      in_run     = 1'b0;
   endtask

   task automatic advance_scan(input logic [PIXEL_W-1:0] pix);
      int unsigned w;
      int unsigned h;
      bit          opaque;
      w      = usable_size(width_reg, MAX_WIDTH);
      h      = usable_size(height_reg, MAX_HEIGHT);
      opaque = !matches_key(pix);
      if (in_run) begin
         if (!opaque) close_run(run_first, col_pos);
      end else if (opaque) begin
         run_first = col_pos;
         in_run    = 1'b1;
      end
      if (col_pos + 1 >= w) begin
         if (in_run) close_run(run_first, col_pos + 1);
         col_pos = 0;
         if (row_pos + 1 >= h) begin
            row_pos    = 0;
            run_number = 0;
         end else begin
            row_pos = row_pos + 1;
         end
      end else begin
         col_pos = col_pos + 1;
      end
   endtask

   always @(posedge clock) begin
      run_rec_t want;
      if (reset) begin
         width_reg  = SIZE_ONE;
         height_reg = SIZE_ONE;
         format_reg = FMT_RGB24;
         key_reg    = '0;
         col_pos    = 0;
         row_pos    = 0;
         in_run     = 1'b0;
         run_first  = 0;
         run_number = 0;
         pending_runs.delete();
      end else begin
         // the run beat leaving now belongs to an older pixel
         if (rsp_valid && rsp_ready) begin
            if (pending_runs.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected run beat left=%0d row=%0d right=%0d index=%0d",
                           $realtime, rsp_run_left, rsp_run_row, rsp_run_right,
                           rsp_run_index);
               fail_count++;
            end else begin
               want = pending_runs.pop_front();
               if (rsp_run_left !== want.left || rsp_run_row !== want.row ||
                   rsp_run_right !== want.right || rsp_run_index !== want.index) begin
                  if (fail_count < 10)
                     $display("%0t: run mismatch exp l=%0d r=%0d rt=%0d i=%0d got l=%0d r=%0d rt=%0d i=%0d",
                              $realtime, want.left, want.row, want.right, want.index,
                              rsp_run_left, rsp_run_row, rsp_run_right, rsp_run_index);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) advance_scan(req_pixel_word);
         if (csr_write_enable) begin
            case (csr_index)
               REG_IMAGE_WIDTH:  width_reg  = csr_write_data[SIZE_W-1:0];
               REG_IMAGE_HEIGHT: height_reg = csr_write_data[SIZE_W-1:0];
               REG_PIXEL_FORMAT: format_reg = csr_write_data[FORMAT_W-1:0];
               REG_KEY_COLOR:    key_reg    = csr_write_data[COLOR_W-1:0];
               default:          ;
            endcase
         end
      end
      runs_pending = pending_runs.size();
   end

endmodule

### dv/tb_top.sv
// Stimulus and verdict for the color-key run extractor. The checker beside
// the block does all prediction and comparison; this module only drives.
module tb_top;
   import cke_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int DRAIN_CYCLES = 8;     // slack for pixels still in the block
   localparam int LONG_HOLD    = 300;   // receiver hold-off, in cycles
   localparam int RANDOM_ITEMS = 1450;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [PIXEL_W-1:0]    req_pixel_word = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [COORD_W-1:0]    rsp_run_left;
   logic [COORD_W-1:0]    rsp_run_row;
   logic [SIZE_W-1:0]     rsp_run_right;
   logic [INDEX_W-1:0]    rsp_run_index;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   int fail_count;
   int runs_pending;
   int cycle_count = 0;

   // sender / receiver idle controls
   bit req_idle_on = 1'b0;
   bit rsp_idle_on = 1'b0;
   int hold_seq    = 0;   // bump to ask the receiver for one long hold-off

   // what the stimulus believes is configured, for building key pixels
   logic [FORMAT_W-1:0] cur_fmt = FMT_RGB24;
   logic [COLOR_W-1:0]  cur_key = '0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   color_key_run_extractor i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_word   (req_pixel_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_run_left     (rsp_run_left),
      .rsp_run_row      (rsp_run_row),
      .rsp_run_right    (rsp_run_right),
      .rsp_run_index    (rsp_run_index),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   cke_run_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_word   (req_pixel_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_run_left     (rsp_run_left),
      .rsp_run_row      (rsp_run_row),
      .rsp_run_right    (rsp_run_right),
      .rsp_run_index    (rsp_run_index),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .runs_pending     (runs_pending)
   );

   // hard stop if the run hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Receiver: short random stalls when enabled, plus one long hold-off per
   // hold_seq bump so the block backs up into the pixel side.
   int hold_seen = 0;
   int hold_left = 0;
   int gap_left  = 0;

   always @(negedge clock) begin
      if (hold_seen != hold_seq) begin
         hold_seen <= hold_seq;
         hold_left <= LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (gap_left != 0) begin
         gap_left  <= gap_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
         gap_left  <= $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Key color laid out as the block sees it; don't-care bits randomized.
   function automatic logic [PIXEL_W-1:0] key_pixel(input logic [FORMAT_W-1:0] fmt,
                                                    input logic [COLOR_W-1:0]  key);
      logic [15:0]        k16;
      logic [23:0]        rgb;
      logic [PIXEL_W-1:0] pix;
      k16 = {key[7:3], key[15:10], key[23:19]};
      rgb = {key[7:0], key[15:8], key[23:16]};
      case (fmt)
         FMT_RGB565: pix = {16'($urandom), k16};
         FMT_RGB24:  pix = {8'($urandom), rgb};
         default:    pix = {8'h00, rgb};
      endcase
      return pix;
   endfunction

   // Non-key pixel: either wide random or a single-bit miss of the key in
   // the compared bits (for 32-bit formats that includes a nonzero top byte).
   function automatic logic [PIXEL_W-1:0] solid_pixel(input logic [FORMAT_W-1:0] fmt,
                                                      input logic [COLOR_W-1:0]  key);
      int nbits;
      nbits = (fmt == FMT_RGB565) ? 16 : (fmt == FMT_RGB24) ? 24 : 32;
      if ($urandom_range(0, 3) == 0)
         return key_pixel(fmt, key) ^ (32'h1 << $urandom_range(0, nbits - 1));
      return $urandom;
   endfunction

   // One pixel beat; valid held until accepted, optional gap before it.
   task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_pixel_word <= pix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Alternating spans of key and non-key pixels, span length 1..max_len.
   task automatic send_stream(input int count, input int max_len);
      int left;
      int len;
      bit opaque;
      left   = count;
      opaque = $urandom_range(0, 1);
      while (left > 0) begin
         len = $urandom_range(1, max_len);
         if (len > left) len = left;
         repeat (len)
            send_pixel(opaque ? solid_pixel(cur_fmt, cur_key) : key_pixel(cur_fmt, cur_key));
         left -= len;
         opaque = !opaque;
      end
   endtask

   // Stop offering and wait until every predicted run beat is back, then let
   // any result-less pixel still in flight clear the pipe.
   task automatic drain();
      req_valid <= 1'b0;
      while (runs_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Holds the write fields for one cycle; enable is lowered by the caller.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
   endtask

   // Unused upper data bits get random garbage; the block must drop them.
   task automatic apply_setup(input logic [SIZE_W-1:0]   w,
                              input logic [SIZE_W-1:0]   h,
                              input logic [FORMAT_W-1:0] fmt,
                              input logic [COLOR_W-1:0]  key);
      write_reg(REG_IMAGE_WIDTH,  {11'($urandom), w});
      write_reg(REG_IMAGE_HEIGHT, {11'($urandom), h});
      write_reg(REG_PIXEL_FORMAT, {22'($urandom), fmt});
      write_reg(REG_KEY_COLOR,    key);
      csr_write_enable <= 1'b0;
      cur_fmt = fmt;
      cur_key = key;
   endtask

   initial begin
      int               phase;
      int               random_items;
      int               n;
      int               pick;
      logic [SIZE_W-1:0]   w;
      logic [SIZE_W-1:0]   h;
      logic [FORMAT_W-1:0] fmt;
      logic [COLOR_W-1:0]  key;

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed ----
      // Reset setup: 1x1 image, 24-bit, key black. Every pixel ends the image,
      // so each non-key pixel is a run [0,1) with index restarting at 0.
      req_idle_on = 1'b0;
      rsp_idle_on <= 1'b1;
      send_pixel(32'h0000_0000);             // key
      send_pixel(32'hff00_0000);             // top byte ignored in 24-bit: key
      send_pixel(32'h0000_0001);             // run closes at image width
      send_pixel(32'hffff_ffff);             // index back to 0 after image end
      drain();

      // RGB565, 4x2: run in the middle of a line, then one filling a line
      apply_setup(13'd4, 13'd2, FMT_RGB565, 24'hff8040);
      send_pixel(key_pixel(cur_fmt, cur_key));
      send_pixel(solid_pixel(cur_fmt, cur_key));
      send_pixel(solid_pixel(cur_fmt, cur_key));
      send_pixel(key_pixel(cur_fmt, cur_key));
      repeat (4) send_pixel(solid_pixel(cur_fmt, cur_key));
      drain();

      // Format code three acts as 32-bit; height zero acts as one
      apply_setup(13'd3, 13'd0, 2'd3, 24'h123456);
      send_pixel({8'h01, 24'h563412});       // nonzero top byte never matches
      send_pixel({8'h00, 24'h563412});       // key
      send_pixel({8'h00, 24'h563413});       // run at last column
      drain();

      // Width above the maximum saturates; then shrink mid-line so the
      // column is already past the new width
      apply_setup(13'h1fff, 13'd3, FMT_RGB32, 24'hffffff);
      send_pixel(32'h00ff_ffff);
      send_pixel(32'h0000_0000);
      send_pixel(32'h0000_0000);
      drain();
      apply_setup(13'd2, 13'd3, FMT_RGB32, 24'hffffff);
      send_pixel(32'h8000_0000);
      send_pixel(32'h00ff_ffff);
      drain();

      // ---- random phases ----
      // Counters are deliberately not realigned between phases, so size
      // changes land mid-image.
      phase        = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)      w = 13'd0;
         else if (pick == 1) w = 13'($urandom_range(4096, 8191));
         else if (pick < 5)  w = 13'($urandom_range(17, 64));
         else                w = 13'($urandom_range(1, 16));
         pick = $urandom_range(0, 9);
         if (pick == 0)      h = 13'd0;
         else if (pick == 1) h = 13'($urandom_range(4096, 8191));
         else                h = 13'($urandom_range(1, 8));
         fmt  = 2'($urandom_range(0, 3));
         pick = $urandom_range(0, 7);
         if (pick == 0)      key = 24'h000000;
         else if (pick == 1) key = 24'hffffff;
         else                key = 24'($urandom);
         apply_setup(w, h, fmt, key);

         n = $urandom_range(20, 150);
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on <= ($urandom_range(0, 3) != 0);
         if (phase == 2) begin
            // receiver goes quiet while pixels keep coming: block must fill
            // and drop req_ready
            req_idle_on = 1'b0;
            hold_seq <= hold_seq + 1;
            n = 150;
         end
         send_stream(n, $urandom_range(1, 10));
         drain();
         random_items += n;
         phase++;
      end

      // ---- closing stretch at full rate on both sides ----
      req_idle_on = 1'b0;
      rsp_idle_on <= 1'b0;
      apply_setup(13'($urandom_range(1, 12)), 13'($urandom_range(1, 4)),
                  2'($urandom_range(0, 3)), 24'($urandom));
      send_stream(200, 6);
      drain();

      if (fail_count == 0 && runs_pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### files.f
rtl/cke_pkg.sv
rtl/color_key_run_extractor.sv
rtl/cke_checker.sv
dv/cke_run_checker.sv
dv/tb_top.sv
